### rtl/core/subpixel_quadratic_refine_core_macros.svh
// ----------------------------------------------------------------------------
// Subpixel quadratic refine: assertion macros
// Concurrent checks clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SUBPIXEL_QUADRATIC_REFINE_CORE_MACROS_SVH
`define SUBPIXEL_QUADRATIC_REFINE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SQR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sqr assertion failed");
// next-cycle implication
`define SQR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sqr assertion failed");
`else
`define SQR_ASSERT_IMPLY(label, ante, cons)
`define SQR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/sqr_pkg.sv
// ----------------------------------------------------------------------------
// Subpixel quadratic refine: package
// Widths, fit constants, solver term codes, FSM states and shared structs.
// ----------------------------------------------------------------------------
package sqr_pkg;

  localparam int SampleW    = 16;
  localparam int CoordBits  = 12;
  localparam int HalfPatch  = 2;
  localparam int PatchSide  = 2 * HalfPatch + 1;
  localparam int PatchCount = PatchSide * PatchSide;
  localparam int IdxW       = $clog2(PatchCount + 1);
  localparam int PosW       = $clog2(PatchSide);
  localparam int WeightW    = 4;

  // dot products stay below 2^21 in magnitude
  localparam int SumW  = 22;
  localparam int SopW  = 31;
  localparam int ProdW = 52;
  localparam int MagW  = ProdW - 1;
  localparam int RemW  = MagW + 1;

  localparam int FracBits = 12;
  localparam int DivSteps = FracBits + 1;
  localparam int StepW    = $clog2(DivSteps);
  localparam int QuoW     = FracBits + 3;
  localparam int OffW     = 15;

  localparam logic signed [SopW-1:0] KDenAb = SopW'(400);
  localparam logic signed [SopW-1:0] KDenEe = SopW'(49);
  localparam logic signed [SopW-1:0] KNum   = SopW'(280);
  localparam logic signed [SopW-1:0] KCross = SopW'(98);

  typedef struct packed {
    logic signed [SumW-1:0] a;
    logic signed [SumW-1:0] b;
    logic signed [SumW-1:0] c;
    logic signed [SumW-1:0] d;
    logic signed [SumW-1:0] e;
  } sqr_coef_t;

  typedef enum logic [2:0] {
    TERM_AB,
    TERM_EE,
    TERM_BC,
    TERM_DE,
    TERM_AD,
    TERM_CE
  } sqr_term_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_MAG,
    ST_CHECK,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_STORE,
    ST_EMIT
  } sqr_state_t;

  typedef struct packed {
    logic      capture;
    logic      load;
    logic      mul;
    logic      acc;
    logic      mag;
    logic      check;
    logic      div_init;
    logic      div_step;
    logic      div_store;
    logic      emit;
    logic      axis;
    sqr_term_t term;
  } sqr_cmd_t;

  typedef struct packed {
    logic rejected;
    logic out_free;
  } sqr_status_t;

endpackage

### rtl/core/sqr_in_if.sv
// ----------------------------------------------------------------------------
// Subpixel quadratic refine: sample channel
// Valid/ready channel carrying one patch sample per transaction.
// ----------------------------------------------------------------------------
interface sqr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sqr_pkg::SampleW-1:0]  sample;
  logic        [sqr_pkg::CoordBits-1:0] corner_x;
  logic        [sqr_pkg::CoordBits-1:0] corner_y;
  logic                                last;

  modport source (output valid, output sample, output corner_x, output corner_y,
                  output last, input ready);
  modport sink (input valid, input sample, input corner_x, input corner_y,
                input last, output ready);
endinterface

### rtl/core/sqr_out_if.sv
// ----------------------------------------------------------------------------
// Subpixel quadratic refine: result channel
// Valid/ready channel carrying one refined corner per transaction.
// ----------------------------------------------------------------------------
interface sqr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [sqr_pkg::CoordBits-1:0] out_x;
  logic        [sqr_pkg::CoordBits-1:0] out_y;
  logic signed [sqr_pkg::OffW-1:0]      offset_x;
  logic signed [sqr_pkg::OffW-1:0]      offset_y;
  logic                                 rejected;

  modport source (output valid, output out_x, output out_y, output offset_x,
                  output offset_y, output rejected, input ready);
  modport sink (input valid, input out_x, input out_y, input offset_x,
                input offset_y, input rejected, output ready);
endinterface

### rtl/core/sqr_accum.sv
// ----------------------------------------------------------------------------
// Subpixel quadratic refine: patch accumulator
// Walks the 5x5 patch and builds the five weighted sums a..e per sample.
// ----------------------------------------------------------------------------
module sqr_accum (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic                               last,
  input  logic signed [sqr_pkg::SampleW-1:0] sample,
  output sqr_pkg::sqr_coef_t                 coef_final
);

  logic [sqr_pkg::IdxW-1:0] idx;
  logic [sqr_pkg::PosW-1:0] xi;
  logic [sqr_pkg::PosW-1:0] yi;
  sqr_pkg::sqr_coef_t       sums;
  sqr_pkg::sqr_coef_t       sums_next;
  logic                     active;

  logic signed [sqr_pkg::WeightW-1:0] xs;
  logic signed [sqr_pkg::WeightW-1:0] ys;
  logic signed [sqr_pkg::WeightW-1:0] wa;
  logic signed [sqr_pkg::WeightW-1:0] wb;
  logic signed [sqr_pkg::WeightW-1:0] we;

  // sample times a small weight in {0, +-1, +-2, +-4}
  function automatic logic signed [sqr_pkg::SumW-1:0] weigh(
    input logic signed [sqr_pkg::SampleW-1:0] s,
    input logic signed [sqr_pkg::WeightW-1:0] w
  );
    logic signed [sqr_pkg::SumW-1:0] se;
    logic signed [sqr_pkg::SumW-1:0] r;
    se = sqr_pkg::SumW'(s);
    unique case (w)
      4'sd1:   r = se;
      -4'sd1:  r = -se;
      4'sd2:   r = se <<< 1;
      -4'sd2:  r = -(se <<< 1);
      4'sd4:   r = se <<< 2;
      -4'sd4:  r = -(se <<< 2);
      default: r = '0;
    endcase
    return r;
  endfunction

  assign active = idx < sqr_pkg::IdxW'(sqr_pkg::PatchCount);
  assign xs = sqr_pkg::WeightW'(xi) - sqr_pkg::WeightW'(sqr_pkg::HalfPatch);
  assign ys = sqr_pkg::WeightW'(yi) - sqr_pkg::WeightW'(sqr_pkg::HalfPatch);
  assign wa = xs * xs - 4'sd2;
  assign wb = ys * ys - 4'sd2;
  assign we = xs * ys;

  always_comb begin
    sums_next = sums;
    if (active) begin
      sums_next.a = sums.a + weigh(sample, wa);
      sums_next.b = sums.b + weigh(sample, wb);
      sums_next.c = sums.c + weigh(sample, xs);
      sums_next.d = sums.d + weigh(sample, ys);
      sums_next.e = sums.e + weigh(sample, we);
    end
  end

  assign coef_final = sums_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      xi   <= '0;
      yi   <= '0;
      sums <= '0;
    end else if (accept) begin
      if (last) begin
        idx  <= '0;
        xi   <= '0;
        yi   <= '0;
        sums <= '0;
      end else if (active) begin
        idx  <= idx + 1'b1;
        sums <= sums_next;
        if (yi == sqr_pkg::PosW'(sqr_pkg::PatchSide - 1)) begin
          yi <= '0;
          xi <= xi + 1'b1;
        end else begin
          yi <= yi + 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/sqr_ctrl.sv
// ----------------------------------------------------------------------------
// Subpixel quadratic refine: solver controller
// Sequences six products, range check, both divisions if not rejected, emit.
// ----------------------------------------------------------------------------
module sqr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 launch,
  input  sqr_pkg::sqr_status_t status,
  output sqr_pkg::sqr_cmd_t    cmd,
  output logic                 busy
);

  sqr_pkg::sqr_state_t       state;
  sqr_pkg::sqr_state_t       state_next;
  sqr_pkg::sqr_term_t        term;
  sqr_pkg::sqr_term_t        term_next;
  logic                      axis;
  logic                      axis_next;
  logic [sqr_pkg::StepW-1:0] step;
  logic [sqr_pkg::StepW-1:0] step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sqr_pkg::ST_IDLE;
      term  <= sqr_pkg::TERM_AB;
      axis  <= 1'b0;
      step  <= '0;
    end else begin
      state <= state_next;
      term  <= term_next;
      axis  <= axis_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    term_next  = term;
    axis_next  = axis;
    step_next  = step;
    cmd        = '0;
    cmd.term   = term;
    cmd.axis   = axis;
    unique case (state)
      sqr_pkg::ST_IDLE: begin
        cmd.capture = launch;
        if (launch) begin
          term_next  = sqr_pkg::TERM_AB;
          state_next = sqr_pkg::ST_LOAD;
        end
      end
      sqr_pkg::ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = sqr_pkg::ST_MUL;
      end
      sqr_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = sqr_pkg::ST_ACC;
      end
      sqr_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        unique case (term)
          sqr_pkg::TERM_AB: term_next = sqr_pkg::TERM_EE;
          sqr_pkg::TERM_EE: term_next = sqr_pkg::TERM_BC;
          sqr_pkg::TERM_BC: term_next = sqr_pkg::TERM_DE;
          sqr_pkg::TERM_DE: term_next = sqr_pkg::TERM_AD;
          sqr_pkg::TERM_AD: term_next = sqr_pkg::TERM_CE;
          default:          term_next = sqr_pkg::TERM_AB;
        endcase
        state_next = (term == sqr_pkg::TERM_CE) ? sqr_pkg::ST_MAG : sqr_pkg::ST_LOAD;
      end
      sqr_pkg::ST_MAG: begin
        cmd.mag    = 1'b1;
        state_next = sqr_pkg::ST_CHECK;
      end
      sqr_pkg::ST_CHECK: begin
        cmd.check  = 1'b1;
        axis_next  = 1'b0;
        state_next = sqr_pkg::ST_DIV_INIT;
      end
      sqr_pkg::ST_DIV_INIT: begin
        if (status.rejected) begin
          state_next = sqr_pkg::ST_EMIT;
        end else begin
          cmd.div_init = 1'b1;
          step_next    = '0;
          state_next   = sqr_pkg::ST_DIV_STEP;
        end
      end
      sqr_pkg::ST_DIV_STEP: begin
        cmd.div_step = 1'b1;
        if (step == sqr_pkg::StepW'(sqr_pkg::DivSteps - 1)) begin
          state_next = sqr_pkg::ST_DIV_STORE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      sqr_pkg::ST_DIV_STORE: begin
        cmd.div_store = 1'b1;
        if (axis) begin
          state_next = sqr_pkg::ST_EMIT;
        end else begin
          axis_next  = 1'b1;
          state_next = sqr_pkg::ST_DIV_INIT;
        end
      end
      sqr_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sqr_pkg::ST_IDLE;
        end
      end
      default: state_next = sqr_pkg::ST_IDLE;
    endcase
  end

  assign busy = state != sqr_pkg::ST_IDLE;

endmodule

### rtl/core/sqr_datapath.sv
// ----------------------------------------------------------------------------
// Subpixel quadratic refine: solver datapath
// Shared multiplier, determinant accumulators, restoring divider, result reg.
// ----------------------------------------------------------------------------
module sqr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  sqr_pkg::sqr_cmd_t                   cmd,
  input  sqr_pkg::sqr_coef_t                  coef_in,
  input  logic [sqr_pkg::CoordBits-1:0]       corner_x,
  input  logic [sqr_pkg::CoordBits-1:0]       corner_y,
  output sqr_pkg::sqr_status_t                status,
  sqr_out_if.source                           results
);

  sqr_pkg::sqr_coef_t                  coef;
  logic [sqr_pkg::CoordBits-1:0]       cx;
  logic [sqr_pkg::CoordBits-1:0]       cy;
  logic signed [sqr_pkg::SopW-1:0]     sop;
  logic signed [sqr_pkg::SumW-1:0]     mop;
  logic signed [sqr_pkg::SopW-1:0]     load_sop;
  logic signed [sqr_pkg::SumW-1:0]     load_mop;
  logic signed [sqr_pkg::SopW+sqr_pkg::SumW-1:0] mul_res;
  logic signed [sqr_pkg::ProdW-1:0]    prod;
  logic signed [sqr_pkg::ProdW-1:0]    den;
  logic signed [sqr_pkg::ProdW-1:0]    nx;
  logic signed [sqr_pkg::ProdW-1:0]    ny;
  logic [sqr_pkg::MagW-1:0]            uden;
  logic [sqr_pkg::MagW-1:0]            unx;
  logic [sqr_pkg::MagW-1:0]            uny;
  logic                                flip_x;
  logic                                flip_y;
  logic                                rej;
  logic [sqr_pkg::RemW-1:0]            rem;
  logic [sqr_pkg::QuoW-1:0]            quo;
  logic signed [sqr_pkg::OffW-1:0]     ox;
  logic signed [sqr_pkg::OffW-1:0]     oy;

  logic [sqr_pkg::RemW-1:0]            num_ext;
  logic [sqr_pkg::RemW-1:0]            den_ext;
  logic [sqr_pkg::RemW-1:0]            den_twice;
  logic [sqr_pkg::RemW-1:0]            rem_shift;
  logic [sqr_pkg::QuoW:0]              quo_inc;
  logic [sqr_pkg::QuoW-1:0]            rounded;
  logic signed [sqr_pkg::OffW-1:0]     off_val;

  function automatic logic [sqr_pkg::MagW-1:0] magnitude(
    input logic signed [sqr_pkg::ProdW-1:0] v
  );
    logic signed [sqr_pkg::ProdW-1:0] p;
    p = v[sqr_pkg::ProdW-1] ? -v : v;
    return p[sqr_pkg::MagW-1:0];
  endfunction

  always_comb begin
    load_sop = '0;
    load_mop = '0;
    unique case (cmd.term)
      sqr_pkg::TERM_AB: begin
        load_sop = sqr_pkg::SopW'(coef.a) * sqr_pkg::KDenAb;
        load_mop = coef.b;
      end
      sqr_pkg::TERM_EE: begin
        load_sop = sqr_pkg::SopW'(coef.e) * sqr_pkg::KDenEe;
        load_mop = coef.e;
      end
      sqr_pkg::TERM_BC: begin
        load_sop = sqr_pkg::SopW'(coef.b) * sqr_pkg::KNum;
        load_mop = coef.c;
      end
      sqr_pkg::TERM_DE: begin
        load_sop = sqr_pkg::SopW'(coef.d) * sqr_pkg::KCross;
        load_mop = coef.e;
      end
      sqr_pkg::TERM_AD: begin
        load_sop = sqr_pkg::SopW'(coef.a) * sqr_pkg::KNum;
        load_mop = coef.d;
      end
      sqr_pkg::TERM_CE: begin
        load_sop = sqr_pkg::SopW'(coef.c) * sqr_pkg::KCross;
        load_mop = coef.e;
      end
      default: begin
        load_sop = '0;
        load_mop = '0;
      end
    endcase
  end

  assign mul_res   = sop * mop;
  assign num_ext   = {1'b0, (cmd.axis ? uny : unx)};
  assign den_ext   = {1'b0, uden};
  assign den_twice = {uden, 1'b0};
  assign rem_shift = {rem[sqr_pkg::RemW-2:0], 1'b0};
  assign quo_inc   = {1'b0, quo} + 1'b1;
  assign rounded   = quo_inc[sqr_pkg::QuoW:1];
  assign off_val   = (cmd.axis ? flip_y : flip_x) ? -$signed(sqr_pkg::OffW'(rounded))
                                                  : $signed(sqr_pkg::OffW'(rounded));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      coef <= coef_in;
      cx   <= corner_x;
      cy   <= corner_y;
    end
    if (cmd.load) begin
      sop <= load_sop;
      mop <= load_mop;
    end
    if (cmd.mul) begin
      prod <= mul_res[sqr_pkg::ProdW-1:0];
    end
    if (cmd.acc) begin
      unique case (cmd.term)
        sqr_pkg::TERM_AB: den <= prod;
        sqr_pkg::TERM_EE: den <= den - prod;
        sqr_pkg::TERM_BC: nx  <= prod;
        sqr_pkg::TERM_DE: nx  <= nx - prod;
        sqr_pkg::TERM_AD: ny  <= prod;
        sqr_pkg::TERM_CE: ny  <= ny - prod;
        default: ;
      endcase
    end
    if (cmd.mag) begin
      uden   <= magnitude(den);
      unx    <= magnitude(nx);
      uny    <= magnitude(ny);
      // offset is -n/den
      flip_x <= nx[sqr_pkg::ProdW-1] == den[sqr_pkg::ProdW-1];
      flip_y <= ny[sqr_pkg::ProdW-1] == den[sqr_pkg::ProdW-1];
    end
    if (cmd.check) begin
      rej <= (uden == '0) || ({1'b0, unx} > den_twice) || ({1'b0, uny} > den_twice);
    end
    if (cmd.div_init) begin
      priority if (num_ext >= den_twice) begin
        rem <= num_ext - den_twice;
        quo <= sqr_pkg::QuoW'(2);
      end else if (num_ext >= den_ext) begin
        rem <= num_ext - den_ext;
        quo <= sqr_pkg::QuoW'(1);
      end else begin
        rem <= num_ext;
        quo <= '0;
      end
    end
    if (cmd.div_step) begin
      if (rem_shift >= den_ext) begin
        rem <= rem_shift - den_ext;
        quo <= {quo[sqr_pkg::QuoW-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quo <= {quo[sqr_pkg::QuoW-2:0], 1'b0};
      end
    end
    if (cmd.div_store) begin
      if (cmd.axis) begin
        oy <= off_val;
      end else begin
        ox <= off_val;
      end
    end
    if (cmd.emit) begin
      results.out_x    <= cx;
      results.out_y    <= cy;
      results.offset_x <= rej ? '0 : ox;
      results.offset_y <= rej ? '0 : oy;
      results.rejected <= rej;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.emit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  assign status.rejected = rej;
  assign status.out_free = !results.valid || results.ready;

endmodule

### rtl/core/subpixel_quadratic_refine_core.sv
// ----------------------------------------------------------------------------
// Subpixel quadratic refine core
// Quadratic least-squares fit over a 5x5 corner-metric patch, subpixel offset.
// ----------------------------------------------------------------------------
// Usage:
//   samples: one Q2.14 sample per transaction, column by column (x outer,
//     y inner), with the corner position; last marks the final sample.
//     An early last treats missing samples as zero; samples past the 25th
//     are ignored until last.
//   results: one transaction per patch with the echoed corner, Q3.12 offsets
//     and the rejected flag (offsets zero when rejected).
// Timing:
//   A sample is taken every cycle, but a last sample is held off until the
//   solver is free. Each of the six products on one shared 31x22 multiplier
//   passes load, multiply and accumulate states; two restoring divisions
//   follow unless the patch is rejected. The next patch accumulates during
//   the solve.
// Reset and stalls:
//   rst clears the patch sums, the sample index and the solver. A stalled
//   results channel holds the output register and the solver waits to emit.
// ----------------------------------------------------------------------------
`include "subpixel_quadratic_refine_core_macros.svh"

module subpixel_quadratic_refine_core (
  input  logic      clk,
  input  logic      rst,
  sqr_in_if.sink    samples,
  sqr_out_if.source results
);

  sqr_pkg::sqr_coef_t   coef_final;
  sqr_pkg::sqr_cmd_t    cmd;
  sqr_pkg::sqr_status_t status;
  logic                 busy;
  logic                 accept;
  logic                 launch;

  assign samples.ready = !(samples.last && busy);
  assign accept        = samples.valid && samples.ready;
  assign launch        = accept && samples.last;

  sqr_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .last       (samples.last),
    .sample     (samples.sample),
    .coef_final (coef_final)
  );

  sqr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .launch (launch),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  sqr_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .coef_in  (coef_final),
    .corner_x (samples.corner_x),
    .corner_y (samples.corner_y),
    .status   (status),
    .results  (results)
  );

  `SQR_ASSERT_NEXT(a_launch_starts_solve, launch, busy)
  `SQR_ASSERT_IMPLY(a_reject_zero_offsets, results.valid && results.rejected, (results.offset_x == '0) && (results.offset_y == '0))
  `SQR_ASSERT_IMPLY(a_offset_range, results.valid, ($signed(results.offset_x) <= 15'sd8192) && ($signed(results.offset_x) >= -15'sd8192) && ($signed(results.offset_y) <= 15'sd8192) && ($signed(results.offset_y) >= -15'sd8192))

endmodule
